// ===== hdl/bounded_deque_with_value_delete_unit_macros.svh =====
// Assertion macros for the checker file of the deque unit.
`ifndef BOUNDED_DEQUE_WITH_VALUE_DELETE_UNIT_MACROS_SVH
`define BOUNDED_DEQUE_WITH_VALUE_DELETE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque unit assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque unit assertion failed");

`endif

// ===== hdl/bdq_pkg.sv =====
// Package with the types, codes and default sizes of the deque unit.
`timescale 1ns / 1ps
`default_nettype none
package bdq_pkg;

  localparam int DEPTH_DEF       = 32;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MODE_W          = 4;
  localparam int KIND_W          = 3;
  localparam int COUNT_W         = 6;
  localparam int ELEM_W          = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 4'd0,
    MODE_PUSH_BACK  = 4'd1,
    MODE_POP_FRONT  = 4'd2,
    MODE_POP_BACK   = 4'd3,
    MODE_CLEAR      = 4'd4,
    MODE_DELETE     = 4'd5,
    MODE_LIST_ALL   = 4'd6,
    MODE_LIST_FIRST = 4'd7,
    MODE_LIST_LAST  = 4'd8
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ELEMENT = 3'd0,
    KIND_EMPTY   = 3'd1,
    KIND_CLEARED = 3'd2,
    KIND_BLANK   = 3'd3,
    KIND_FULL    = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LIST = 3'b010,
    ST_DEL  = 3'b100
  } state_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic shr;
    logic shl;
    logic app;
    logic del;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/bdq_cell.sv =====
// One storage cell of the deque chain, holding the entry at a fixed position.
`timescale 1ns / 1ps
`default_nettype none
module bdq_cell #(
  parameter int VW  = bdq_pkg::VALUE_WIDTH_DEF,
  parameter int CW  = 6,
  parameter int IDX = 0
) (
  input  wire logic                clk,
  input  wire bdq_pkg::cell_ctl_t  ctl,
  input  wire logic [CW-1:0]       cnt,
  input  wire logic signed [VW-1:0] push_word,
  input  wire logic signed [VW-1:0] del_word,
  input  wire logic signed [VW-1:0] left_word,
  input  wire logic signed [VW-1:0] right_word,
  input  wire logic                shift_in,
  output logic                     shift_out,
  output logic signed [VW-1:0]     word
);

  logic signed [VW-1:0] word_r;
  logic signed [VW-1:0] word_nxt;
  logic                 in_use;
  logic                 match;

  assign in_use    = CW'(IDX) < cnt;
  assign match     = in_use && (word_r == del_word);
  assign shift_out = shift_in || match;
  assign word      = word_r;

  always_comb begin
    word_nxt = word_r;
    if (ctl.shr) begin
      word_nxt = left_word;
    end else if (ctl.shl) begin
      word_nxt = right_word;
    end else if (ctl.app && (cnt == CW'(IDX))) begin
      word_nxt = push_word;
    end else if (ctl.del && shift_out) begin
      word_nxt = right_word;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/bounded_deque_with_value_delete_unit.sv =====
// Top level of the bounded deque with delete by value, built as a chain of cells.
// Push, pop and clear never leave idle; any notice appears on the cycle after the request.
// A listing keeps busy high while the chain rotates once around;
// elements leave one per cycle, each taken from the front cell and registered onto the outputs.
// Delete by value removes one match per cycle and returns to idle once no entry matches.
// Reset empties the deque and clears the strobe; entry contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module bounded_deque_with_value_delete_unit #(
  parameter int DEPTH       = bdq_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = bdq_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [bdq_pkg::MODE_W-1:0]         in_mode,
  input  wire logic signed [bdq_pkg::ELEM_W-1:0]  in_value,
  input  wire logic [bdq_pkg::COUNT_W-1:0]        in_count,
  output logic                                    out_valid,
  output logic [bdq_pkg::KIND_W-1:0]              out_kind,
  output logic signed [bdq_pkg::ELEM_W-1:0]       out_element,
  output logic                                    out_last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  bdq_pkg::state_t              state_r, state_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [IW-1:0]                k_r, k_nxt;
  logic [IW-1:0]                lo_r, lo_nxt;
  logic [IW-1:0]                hi_r, hi_nxt;
  logic signed [VALUE_WIDTH-1:0] del_word_r, del_word_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [bdq_pkg::KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic signed [bdq_pkg::ELEM_W-1:0] out_element_r, out_element_nxt;
  logic                         out_last_r, out_last_nxt;

  bdq_pkg::cell_ctl_t           ctl;
  logic signed [VALUE_WIDTH-1:0] in_word;
  logic signed [VALUE_WIDTH-1:0] cell_word [DEPTH];
  logic [DEPTH:0]               sh;
  logic                         any_match;
  logic [CW-1:0]                n_sat;
  logic [CW-1:0]                n_sel;
  logic [CW-1:0]                n_list;
  logic [CW-1:0]                lo_list;

  assign in_word   = VALUE_WIDTH'(in_value);
  assign sh[0]     = 1'b0;
  assign any_match = sh[DEPTH];

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic signed [VALUE_WIDTH-1:0] left_w;
      logic signed [VALUE_WIDTH-1:0] right_w;
      if (gi == 0) begin : g_first
        assign left_w = in_word;
      end else begin : g_mid_l
        assign left_w = cell_word[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_end
        assign right_w = cell_word[0];
      end else begin : g_mid_r
        assign right_w = cell_word[gi+1];
      end
      bdq_cell #(
        .VW  (VALUE_WIDTH),
        .CW  (CW),
        .IDX (gi)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .cnt        (cnt_r),
        .push_word  (in_word),
        .del_word   (del_word_r),
        .left_word  (left_w),
        .right_word (right_w),
        .shift_in   (sh[gi]),
        .shift_out  (sh[gi+1]),
        .word       (cell_word[gi])
      );
    end
  endgenerate

  always_comb begin
    if (int'(in_count) > DEPTH) begin
      n_sat = CW'(DEPTH);
    end else begin
      n_sat = CW'(in_count);
    end
    n_sel = (n_sat < cnt_r) ? n_sat : cnt_r;
  end

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    k_nxt           = k_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    del_word_nxt    = del_word_r;
    ctl             = '0;
    out_valid_nxt   = 1'b0;
    out_kind_nxt    = bdq_pkg::KIND_ELEMENT;
    out_element_nxt = '0;
    out_last_nxt    = 1'b0;
    n_list          = cnt_r;
    lo_list         = '0;

    case (state_r)
      bdq_pkg::ST_IDLE: begin
        if (start) begin
          case (in_mode)
            bdq_pkg::MODE_PUSH_FRONT, bdq_pkg::MODE_PUSH_BACK: begin
              if (cnt_r == CW'(DEPTH)) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = bdq_pkg::KIND_FULL;
                out_last_nxt  = 1'b1;
              end else begin
                ctl.shr = (in_mode == bdq_pkg::MODE_PUSH_FRONT);
                ctl.app = (in_mode == bdq_pkg::MODE_PUSH_BACK);
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            bdq_pkg::MODE_POP_FRONT, bdq_pkg::MODE_POP_BACK: begin
              if (cnt_r == '0) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = bdq_pkg::KIND_EMPTY;
                out_last_nxt  = 1'b1;
              end else begin
                ctl.shl = (in_mode == bdq_pkg::MODE_POP_FRONT);
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            bdq_pkg::MODE_CLEAR: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              if (cnt_r == '0) begin
                out_kind_nxt = bdq_pkg::KIND_EMPTY;
              end else begin
                out_kind_nxt = bdq_pkg::KIND_CLEARED;
                cnt_nxt      = '0;
              end
            end
            bdq_pkg::MODE_DELETE: begin
              del_word_nxt = in_word;
              state_nxt    = bdq_pkg::ST_DEL;
            end
            bdq_pkg::MODE_LIST_ALL, bdq_pkg::MODE_LIST_FIRST,
            bdq_pkg::MODE_LIST_LAST: begin
              if (in_mode != bdq_pkg::MODE_LIST_ALL) begin
                n_list = n_sel;
              end
              if (in_mode == bdq_pkg::MODE_LIST_LAST) begin
                lo_list = cnt_r - n_sel;
              end
              if (cnt_r == '0) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = bdq_pkg::KIND_EMPTY;
                out_last_nxt  = 1'b1;
              end else if (n_list == '0) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = bdq_pkg::KIND_BLANK;
                out_last_nxt  = 1'b1;
              end else begin
                k_nxt     = '0;
                lo_nxt    = IW'(lo_list);
                hi_nxt    = IW'(lo_list + n_list - 1'b1);
                state_nxt = bdq_pkg::ST_LIST;
              end
            end
            default: begin
            end
          endcase
        end
      end
      bdq_pkg::ST_LIST: begin
        ctl.shl = 1'b1;
        k_nxt   = k_r + 1'b1;
        if ((k_r >= lo_r) && (k_r <= hi_r)) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = bdq_pkg::KIND_ELEMENT;
          out_element_nxt = bdq_pkg::ELEM_W'(cell_word[0]);
          out_last_nxt    = (k_r == hi_r);
        end
        if (k_r == IW'(DEPTH - 1)) begin
          state_nxt = bdq_pkg::ST_IDLE;
        end
      end
      bdq_pkg::ST_DEL: begin
        ctl.del = 1'b1;
        if (any_match) begin
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          state_nxt = bdq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bdq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdq_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r           <= k_nxt;
    lo_r          <= lo_nxt;
    hi_r          <= hi_nxt;
    del_word_r    <= del_word_nxt;
    out_kind_r    <= out_kind_nxt;
    out_element_r <= out_element_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign busy        = (state_r != bdq_pkg::ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_element = out_element_r;
  assign out_last    = out_last_r;

endmodule
`default_nettype wire

// ===== hdl/bdq_checker.sv =====
// Port-level checker for the deque unit and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_deque_with_value_delete_unit_macros.svh"
module bdq_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic [bdq_pkg::MODE_W-1:0]         in_mode,
  input wire logic                               out_valid,
  input wire logic [bdq_pkg::KIND_W-1:0]         out_kind,
  input wire logic signed [bdq_pkg::ELEM_W-1:0]  out_element,
  input wire logic                               out_last
);

  logic notice;
  logic push_req;
  logic clear_req;

  assign notice    = out_valid && (out_kind != bdq_pkg::KIND_ELEMENT);
  assign push_req  = start && !busy && (in_mode == bdq_pkg::MODE_PUSH_BACK);
  assign clear_req = start && !busy && (in_mode == bdq_pkg::MODE_CLEAR);

  // A notice is always the only result of its request.
  `BDQ_ASSERT_NOW(a_notice_last, clk, rst_n, notice, out_last)
  `BDQ_ASSERT_NOW(a_notice_zero, clk, rst_n, notice, out_element == '0)
  // A push to the back gives at most a full refusal on the next cycle.
  `BDQ_ASSERT_NEXT(a_push_quiet, clk, rst_n, push_req, !out_valid || out_kind == bdq_pkg::KIND_FULL)
  // A clear always answers on the next cycle with an empty or cleared notice.
  `BDQ_ASSERT_NEXT(a_clear_ans, clk, rst_n, clear_req, out_valid && (out_kind == bdq_pkg::KIND_EMPTY || out_kind == bdq_pkg::KIND_CLEARED))

endmodule

bind bounded_deque_with_value_delete_unit bdq_checker u_bdq_checker (.*);
`default_nettype wire
